@@ hw/rtl/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// bss_pkg
// Shared constants, types and helpers of the bilinear sprite scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  // Sprite store geometry.
  localparam int SRC_DIM     = 256;
  localparam int SRC_AW      = 8;
  localparam int DST_DIM     = 4096;
  localparam int FRAC_BITS   = 8;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int NUM_BANKS   = 4;
  localparam int BANK_AW     = 2 * SRC_AW - 2;
  localparam int BANK_DEPTH  = 1 << BANK_AW;

  // Quotient is integer part plus fraction; one bit is resolved per stage.
  localparam int Q_W         = SRC_AW + FRAC_BITS;
  localparam int DIV_STAGES  = Q_W;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_DST_LEFT   = 3'd4,
    REG_DST_TOP    = 3'd5
  } reg_idx_t;

  // Item fields carried down the pipeline.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  ld_col;
    logic [7:0]  ld_row;
    logic [31:0] ld_color;
    logic [12:0] frame_x;
    logic [12:0] frame_y;
    logic        oor;
  } item_t;

  // One divider stage: partial remainders and the numerator/quotient shifters.
  typedef struct packed {
    item_t       it;
    logic [11:0] rem_x;
    logic [11:0] rem_y;
    logic [15:0] nq_x;
    logic [15:0] nq_y;
  } div_t;

  // One restoring division step: {remainder, shifted numerator/quotient}.
  function automatic logic [27:0] div_step(logic [11:0] rem, logic [15:0] nq,
                                           logic [12:0] d);
    logic [12:0] r;
    logic [12:0] diff;
    logic        ge;
    r    = {rem, nq[15]};
    ge   = (r >= d);
    diff = r - d;
    return {(ge ? diff[11:0] : r[11:0]), nq[14:0], ge};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bilinear_sprite_scaler.sv @@
// ----------------------------------------------------------------------------
// bilinear_sprite_scaler
// Scales a stored ARGB8888 sprite to a destination rectangle, one pixel a cycle unless stalled.
// ----------------------------------------------------------------------------
// The input stream carries two kinds of transfer, chosen by in_tuser. A load
// (in_tuser 0) writes one source pixel into the sprite store; a render
// (in_tuser 1) asks for one destination pixel and yields one output transfer
// holding the interpolated color, the framebuffer coordinate and a flag for
// requests outside the destination size (color then reads as zero).
// Registers must be written over the APB port only while the stream is idle;
// the block does not enforce it. A new item is taken every cycle while the
// receiver does not stall. A render result passes the input stage, the 16-stage
// pipelined divider that maps the destination coordinate into the source, then
// the registers of the store read and of the two interpolation multiplies.
// The store is four banks by row and column parity, so all four neighbors
// are read in the same cycle; loads write at the same pipeline stage as renders
// read, which keeps the stream order exact.
// When the receiver stalls a valid output the whole pipeline holds and
// in_tready drops. Reset clears the pipeline valids, sets the sizes to one and
// the offsets to zero; the store contents are undefined until loaded.
`default_nettype none

module bilinear_sprite_scaler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // APB configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // load_col[7:0], load_row[15:8], load_color[47:16], out_col[59:48],
  // out_row[71:60]
  input  wire logic [71:0] in_tdata,
  // cmd[0]
  input  wire logic [0:0]  in_tuser,
  // Output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // color[31:0], frame_x[44:32], frame_y[57:45], zero fill [63:58]
  output logic      [63:0] out_tdata,
  // out_of_range[0]
  output logic      [0:0]  out_tuser
);
  import bss_pkg::*;

  // Configuration registers.
  logic [8:0]  src_width_r, src_height_r;
  logic [12:0] dst_width_r, dst_height_r;
  logic [11:0] dst_left_r, dst_top_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 9'd1;
      src_height_r <= 9'd1;
      dst_width_r  <= 13'd1;
      dst_height_r <= 13'd1;
      dst_left_r   <= 12'd0;
      dst_top_r    <= 12'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SRC_WIDTH:  src_width_r  <= cfg_pwdata[8:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_pwdata[8:0];
        REG_DST_WIDTH:  dst_width_r  <= cfg_pwdata[12:0];
        REG_DST_HEIGHT: dst_height_r <= cfg_pwdata[12:0];
        REG_DST_LEFT:   dst_left_r   <= cfg_pwdata[11:0];
        REG_DST_TOP:    dst_top_r    <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_idx)
      REG_SRC_WIDTH:  cfg_prdata = {23'd0, src_width_r};
      REG_SRC_HEIGHT: cfg_prdata = {23'd0, src_height_r};
      REG_DST_WIDTH:  cfg_prdata = {19'd0, dst_width_r};
      REG_DST_HEIGHT: cfg_prdata = {19'd0, dst_height_r};
      REG_DST_LEFT:   cfg_prdata = {20'd0, dst_left_r};
      REG_DST_TOP:    cfg_prdata = {20'd0, dst_top_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // Sizes saturated to their legal ranges.
  logic [8:0]  sw, sh;
  logic [12:0] dw, dh;

  assign sw = (src_width_r == 9'd0) ? 9'd1 :
              (src_width_r > 9'(SRC_DIM)) ? 9'(SRC_DIM) : src_width_r;
  assign sh = (src_height_r == 9'd0) ? 9'd1 :
              (src_height_r > 9'(SRC_DIM)) ? 9'(SRC_DIM) : src_height_r;
  assign dw = (dst_width_r == 13'd0) ? 13'd1 :
              (dst_width_r > 13'(DST_DIM)) ? 13'(DST_DIM) : dst_width_r;
  assign dh = (dst_height_r == 13'd0) ? 13'd1 :
              (dst_height_r > 13'(DST_DIM)) ? 13'(DST_DIM) : dst_height_r;

  // The whole pipeline moves when the output register is free or drained.
  logic adv;
  logic out_tvalid_r;

  assign adv        = !out_tvalid_r || out_tready;
  assign in_tready  = adv;

  // Input stage: unpack, frame coordinate, range check and scaling product.
  logic [11:0] in_ocol, in_orow;
  item_t       st1_nxt, st1_r;
  logic [20:0] prod_x_nxt, prod_y_nxt, prod_x_r, prod_y_r;
  logic        st1_vld_r;

  assign in_ocol = in_tdata[59:48];
  assign in_orow = in_tdata[71:60];

  always_comb begin
    st1_nxt.cmd      = in_tuser[0];
    st1_nxt.ld_col   = in_tdata[7:0];
    st1_nxt.ld_row   = in_tdata[15:8];
    st1_nxt.ld_color = in_tdata[47:16];
    st1_nxt.frame_x  = {1'b0, dst_left_r} + {1'b0, in_ocol};
    st1_nxt.frame_y  = {1'b0, dst_top_r} + {1'b0, in_orow};
    st1_nxt.oor      = ({1'b0, in_ocol} >= dw) || ({1'b0, in_orow} >= dh);
    prod_x_nxt       = {9'd0, in_ocol} * {12'd0, sw};
    prod_y_nxt       = {9'd0, in_orow} * {12'd0, sh};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_vld_r <= 1'b0;
    end else if (adv) begin
      st1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_r    <= st1_nxt;
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
    end
  end

  // Divider pipeline: position = product * ONE / dst, one quotient bit a stage.
  div_t                  div_in  [DIV_STAGES];
  div_t                  div_nxt [DIV_STAGES];
  div_t                  div_r   [DIV_STAGES];
  logic [DIV_STAGES-1:0] div_vld_r;
  logic [27:0]           step_x  [DIV_STAGES];
  logic [27:0]           step_y  [DIV_STAGES];

  always_comb begin
    div_in[0].it    = st1_r;
    div_in[0].rem_x = prod_x_r[19:FRAC_BITS];
    div_in[0].rem_y = prod_y_r[19:FRAC_BITS];
    div_in[0].nq_x  = {prod_x_r[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    div_in[0].nq_y  = {prod_y_r[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    for (int k = 1; k < DIV_STAGES; k++) begin
      div_in[k] = div_r[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      step_x[k]        = div_step(div_in[k].rem_x, div_in[k].nq_x, dw);
      step_y[k]        = div_step(div_in[k].rem_y, div_in[k].nq_y, dh);
      div_nxt[k].it    = div_in[k].it;
      div_nxt[k].rem_x = step_x[k][27:16];
      div_nxt[k].nq_x  = step_x[k][15:0];
      div_nxt[k].rem_y = step_y[k][27:16];
      div_nxt[k].nq_y  = step_y[k][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r <= '0;
    end else if (adv) begin
      div_vld_r <= {div_vld_r[DIV_STAGES-2:0], st1_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r <= div_nxt;
    end
  end

  // Neighbor addresses: integer part, clamped +1 neighbor, bank split.
  div_t        dq;
  logic [7:0]  x0, y0, x1, y1;
  logic [7:0]  fx_d, fy_d;
  logic [8:0]  x0p1, y0p1;
  logic [7:0]  csel [NUM_BANKS];
  logic [7:0]  rsel [NUM_BANKS];
  logic [BANK_AW-1:0] raddr [NUM_BANKS];
  logic [BANK_AW-1:0] waddr;
  logic [1:0]  wbank;
  logic        we;

  assign dq   = div_r[DIV_STAGES-1];
  assign x0   = dq.nq_x[Q_W-1:FRAC_BITS];
  assign y0   = dq.nq_y[Q_W-1:FRAC_BITS];
  assign fx_d = dq.nq_x[FRAC_BITS-1:0];
  assign fy_d = dq.nq_y[FRAC_BITS-1:0];
  assign x0p1 = {1'b0, x0} + 9'd1;
  assign y0p1 = {1'b0, y0} + 9'd1;
  assign x1   = (x0p1 < sw) ? x0p1[7:0] : x0;
  assign y1   = (y0p1 < sh) ? y0p1[7:0] : y0;

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      csel[b]  = (x0[0] == b[0]) ? x0 : x1;
      rsel[b]  = (y0[0] == b[1]) ? y0 : y1;
      raddr[b] = {rsel[b][7:1], csel[b][7:1]};
    end
  end

  assign we    = div_vld_r[DIV_STAGES-1] && !dq.it.cmd;
  assign wbank = {dq.it.ld_row[0], dq.it.ld_col[0]};
  assign waddr = {dq.it.ld_row[7:1], dq.it.ld_col[7:1]};

  // Sprite store: four banks, each one write and one registered read a cycle while the pipeline advances.
  logic [31:0] rd_r [NUM_BANKS];

  for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
    logic [31:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (adv) begin
        rd_r[gb] <= mem[raddr[gb]];
        if (we && (wbank == 2'(gb))) begin
          mem[waddr] <= dq.it.ld_color;
        end
      end
    end
  end

  // Read stage side information.
  item_t      mr_it_r;
  logic [7:0] mr_fx_r, mr_fy_r;
  logic       mr_x0p_r, mr_x1p_r, mr_y0p_r, mr_y1p_r;
  logic       mr_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mr_vld_r <= 1'b0;
    end else if (adv) begin
      mr_vld_r <= div_vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mr_it_r  <= dq.it;
      mr_fx_r  <= fx_d;
      mr_fy_r  <= fy_d;
      mr_x0p_r <= x0[0];
      mr_x1p_r <= x1[0];
      mr_y0p_r <= y0[0];
      mr_y1p_r <= y1[0];
    end
  end

  // Horizontal interpolation of each channel.
  logic [31:0] c00, c01, c10, c11;
  logic [8:0]  wx0, wy0;
  logic [16:0] top_full [4];
  logic [16:0] bot_full [4];

  assign c00 = rd_r[{mr_y0p_r, mr_x0p_r}];
  assign c01 = rd_r[{mr_y0p_r, mr_x1p_r}];
  assign c10 = rd_r[{mr_y1p_r, mr_x0p_r}];
  assign c11 = rd_r[{mr_y1p_r, mr_x1p_r}];
  assign wx0 = 9'(ONE) - {1'b0, mr_fx_r};

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      top_full[s] = {9'd0, c00[8*s +: 8]} * {8'd0, wx0}
                  + {9'd0, c01[8*s +: 8]} * {9'd0, mr_fx_r};
      bot_full[s] = {9'd0, c10[8*s +: 8]} * {8'd0, wx0}
                  + {9'd0, c11[8*s +: 8]} * {9'd0, mr_fx_r};
    end
  end

  logic [15:0] ip_top_r [4];
  logic [15:0] ip_bot_r [4];
  logic [7:0]  ip_fy_r;
  item_t       ip_it_r;
  logic        ip_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_vld_r <= 1'b0;
    end else if (adv) begin
      ip_vld_r <= mr_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < 4; s++) begin
        ip_top_r[s] <= top_full[s][15:0];
        ip_bot_r[s] <= bot_full[s][15:0];
      end
      ip_fy_r <= mr_fy_r;
      ip_it_r <= mr_it_r;
    end
  end

  // Vertical interpolation and truncation.
  logic [24:0] vert [4];
  logic [31:0] color_nxt;

  assign wy0 = 9'(ONE) - {1'b0, ip_fy_r};

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      vert[s] = {9'd0, ip_top_r[s]} * {16'd0, wy0}
              + {9'd0, ip_bot_r[s]} * {17'd0, ip_fy_r};
      color_nxt[8*s +: 8] = vert[s][2*FRAC_BITS +: 8];
    end
  end

  // Output register.
  logic [31:0] out_color_r;
  logic [12:0] out_fx_r, out_fy_r;
  logic        out_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= ip_vld_r && ip_it_r.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_color_r <= ip_it_r.oor ? 32'd0 : color_nxt;
      out_fx_r    <= ip_it_r.frame_x;
      out_fy_r    <= ip_it_r.frame_y;
      out_oor_r   <= ip_it_r.oor;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_fy_r, out_fx_r, out_color_r};
  assign out_tuser  = out_oor_r;

endmodule

`default_nettype wire

@@ tb/sv/bss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_checker
// Watches both streams and the APB port of the sprite scaler, keeps its own
// copy of the sprite and the registers, predicts each render result and
// compares it field by field with the output transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic [0:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [63:0] out_tdata,
  input  wire logic [0:0]  out_tuser,
  output int               fail_count,
  output int               pending_pixels
);
  import bss_pkg::*;

  typedef struct packed {
    logic [31:0] color;
    logic [12:0] fx;
    logic [12:0] fy;
    logic        oor;
  } pixel_t;

  logic [31:0] sprite [int];
  logic [8:0]  sw_q, sh_q;
  logic [12:0] dw_q, dh_q;
  logic [11:0] left_q, top_q;
  pixel_t      expected_pixels[$];

  assign pending_pixels = expected_pixels.size();

  function automatic int clamp_dim(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Bilinear interpolation of one destination pixel.
  function automatic pixel_t scale_pixel(logic [11:0] oc, logic [11:0] orow);
    pixel_t p;
    int sw, sh, dw, dh, x0, y0, x1, y1;
    longint px, py, fx, fy, top, bot, v;
    logic [31:0] c00, c01, c10, c11;
    sw = clamp_dim(sw_q, SRC_DIM);
    sh = clamp_dim(sh_q, SRC_DIM);
    dw = clamp_dim(dw_q, DST_DIM);
    dh = clamp_dim(dh_q, DST_DIM);
    p.fx = {1'b0, left_q} + {1'b0, oc};
    p.fy = {1'b0, top_q} + {1'b0, orow};
    p.color = '0;
    p.oor = (oc >= dw) || (orow >= dh);
    if (p.oor) return p;
    px = (longint'(oc) * sw * ONE) / dw;
    py = (longint'(orow) * sh * ONE) / dh;
    x0 = int'(px >> FRAC_BITS);
    y0 = int'(py >> FRAC_BITS);
    fx = px & (ONE - 1);
    fy = py & (ONE - 1);
    x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
    y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
    c00 = sprite.exists(y0 * SRC_DIM + x0) ? sprite[y0 * SRC_DIM + x0] : '0;
    c01 = sprite.exists(y0 * SRC_DIM + x1) ? sprite[y0 * SRC_DIM + x1] : '0;
    c10 = sprite.exists(y1 * SRC_DIM + x0) ? sprite[y1 * SRC_DIM + x0] : '0;
    c11 = sprite.exists(y1 * SRC_DIM + x1) ? sprite[y1 * SRC_DIM + x1] : '0;
    for (int s = 0; s < 32; s += 8) begin
      top = longint'((c00 >> s) & 8'hFF) * (ONE - fx)
          + longint'((c01 >> s) & 8'hFF) * fx;
      bot = longint'((c10 >> s) & 8'hFF) * (ONE - fx)
          + longint'((c11 >> s) & 8'hFF) * fx;
      v = (top * (ONE - fy) + bot * fy) >> (2 * FRAC_BITS);
      p.color[s +: 8] = v[7:0];
    end
    return p;
  endfunction

  // Register writes, input transfers and output checks, all at the clock edge.
  always @(posedge clk) begin
    pixel_t want, got;
    if (!rst_n) begin
      sw_q <= 9'd1; sh_q <= 9'd1; dw_q <= 13'd1; dh_q <= 13'd1;
      left_q <= '0; top_q <= '0;
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_SRC_WIDTH:  sw_q   <= cfg_pwdata[8:0];
          REG_SRC_HEIGHT: sh_q   <= cfg_pwdata[8:0];
          REG_DST_WIDTH:  dw_q   <= cfg_pwdata[12:0];
          REG_DST_HEIGHT: dh_q   <= cfg_pwdata[12:0];
          REG_DST_LEFT:   left_q <= cfg_pwdata[11:0];
          REG_DST_TOP:    top_q  <= cfg_pwdata[11:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == 1'b0)
          sprite[in_tdata[15:8] * SRC_DIM + in_tdata[7:0]] = in_tdata[47:16];
        else
          expected_pixels.push_back(scale_pixel(in_tdata[59:48], in_tdata[71:60]));
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[44:32], out_tdata[57:45], out_tuser[0]};
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected output transfer, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want !== got) begin
            $display({"%0t: mismatch color exp %h act %h, x exp %0d act %0d, ",
                      "y exp %0d act %0d, oor exp %0b act %0b"},
                     $time, want.color, got.color, want.fx, got.fx, want.fy, got.fy,
                     want.oor, got.oor);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

@@ tb/sv/tb_bilinear_sprite_scaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_sprite_scaler
// Loads sprites, renders scaled pixels under several register settings and
// random stream idling; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bilinear_sprite_scaler;
  import bss_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  int          fail_count, pending_pixels;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          cur_sw = 1, cur_sh = 1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bilinear_sprite_scaler dut (.*);

  bss_checker u_checker (.*);

  // Receiver: random stall, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx) << 2; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Sends one item; valid stays high across back-to-back transfers.
  task automatic send_item(logic cmd, logic [71:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic load_pixel(int c, int r, logic [31:0] color);
    send_item(1'b0, {24'(0), color, 8'(r), 8'(c)});
  endtask

  task automatic render(logic [11:0] oc, logic [11:0] orow);
    send_item(1'b1, {orow, oc, 48'(0)});
  endtask

  // Waits until the block is drained, with margin for trailing loads.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // New sprite of size w x h, fully loaded with random colors.
  task automatic new_sprite(int w, int h);
    drain();
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    cur_sw = w; cur_sh = h;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) load_pixel(c, r, $urandom);
  endtask

  task automatic set_dest(int dw, int dh, int lft, int tp);
    drain();
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_DST_LEFT, lft);
    write_reg(REG_DST_TOP, tp);
  endtask

  // One random phase: mostly in-range renders, some out of range, some loads.
  task automatic random_phase(int n, int dw, int dh);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 15)
        load_pixel($urandom_range(cur_sw - 1), $urandom_range(cur_sh - 1), $urandom);
      else if (k < 25)
        render($urandom, $urandom);
      else
        render($urandom_range(dw - 1), $urandom_range(dh - 1));
    end
  endtask

  initial begin
    #100000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: loads at the store corners, corners of the destination,
    // out-of-range requests and the largest framebuffer offset.
    send_idle_pct = 25; recv_idle_pct = 83;
    load_pixel(255, 255, 32'hFFFF_FFFF);
    load_pixel(0, 255, 32'h0);
    load_pixel(255, 0, 32'hA5A5_5A5A);
    new_sprite(2, 2);
    set_dest(4096, 4096, 4095, 4095);
    render(0, 0);
    render(4095, 4095);
    render(4095, 0);
    render(1, 4095);
    drain();
    set_dest(3, 5, 0, 0);
    render(2, 4);
    render(3, 0);
    render(0, 5);
    render(12'hFFF, 12'hFFF);
    render(1, 2);
    drain();
    // Shrink a 256x1 source row to 1x1 and 7x1 at the largest source width.
    write_reg(REG_SRC_WIDTH, 256);
    write_reg(REG_SRC_HEIGHT, 1);
    cur_sw = 256; cur_sh = 1;
    for (int c = 0; c < 256; c++) load_pixel(c, 0, $urandom);
    set_dest(1, 1, 17, 3);
    render(0, 0);
    set_dest(7, 1, 0, 0);
    for (int c = 0; c < 7; c++) render(c, 0);
    drain();

    // Random phases over varied settings and idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      int w, h, dw, dh;
      if (ph == 2) begin send_idle_pct = 83; recv_idle_pct = 25; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      w = (ph == 5) ? 1 : $urandom_range(1, 12);
      h = (ph == 3) ? 1 : $urandom_range(1, 12);
      dw = (ph == 1) ? 4096 : $urandom_range(1, 40);
      dh = (ph == 0) ? 1 : $urandom_range(1, 40);
      new_sprite(w, h);
      set_dest(dw, dh, $urandom_range(4095), $urandom_range(4095));
      if (ph == 4) hold_cycles = 200;
      random_phase(200, dw, dh);
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

`default_nettype wire

@@ bilinear_sprite_scaler.f @@
hw/rtl/bss_pkg.sv
hw/rtl/bilinear_sprite_scaler.sv
tb/sv/bss_checker.sv
tb/sv/tb_bilinear_sprite_scaler.sv
